### design/gcc_pkg.sv
package gcc_pkg;

  localparam int CNT_W = 12;

  localparam logic REQ_MEASURE = 1'b0;
  localparam logic REQ_TICK    = 1'b1;

  localparam logic [1:0] DUTY_OFF  = 2'd0;
  localparam logic [1:0] DUTY_HALF = 2'd1;
  localparam logic [1:0] DUTY_FULL = 2'd2;

  localparam logic DIR_OPEN  = 1'b0;
  localparam logic DIR_CLOSE = 1'b1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_HUM_LOW    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HUM_HIGH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_LOW   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_HIGH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_LOW  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_HIGH = 3'd5;

  typedef struct packed {
    logic [6:0]  hum_low;
    logic [6:0]  hum_high;
    logic [6:0]  temp_low;
    logic [6:0]  temp_high;
    logic [15:0] light_low;
    logic [15:0] light_high;
  } cfg_t;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  temperature;
    logic [6:0]  humidity;
    logic [15:0] light_level;
  } item_t;

  typedef struct packed {
    logic       fan_on;
    logic       heater_on;
    logic       humidifier_on;
    logic       dehumidifier_on;
    logic       alarm_on;
    logic [3:0] coil_pattern;
    logic       shade_is_open;
    logic       shade_busy;
  } result_t;

  // Opening walks the coils from phase 3 down to phase 0, closing walks upward.
  function automatic logic [3:0] coil_seq(input logic dir, input logic [1:0] idx);
    logic [3:0] pat;
    if (dir == DIR_CLOSE) begin
      pat = 4'b0001 << idx;
    end else begin
      pat = 4'b1000 >> idx;
    end
    return pat;
  endfunction

endpackage

### design/greenhouse_climate_controller_unit.sv
// Greenhouse climate controller. Each input transaction is either a
// measurement (req_type 0) or a 1 ms tick (req_type 1) and yields exactly one
// result transaction showing fan, heater, humidity, alarm and shade state after
// the update. One transaction is accepted per clock while in_ready is high.
// It passes from the input register into the result register, which offers
// its result. The climate and shade state updates as the transaction moves
// from one register to the other.
// A stalled output holds the result register and, once the input register is
// also full, drops in_ready. Thresholds are written through cfg_we, cfg_index
// and cfg_data; the user must write them only while the block is idle, as the
// block itself does not enforce this.
module greenhouse_climate_controller_unit #(
  parameter int PWM_PERIOD  = 3000,
  parameter int SHADE_STEPS = 2150,
  parameter int STEP_TICKS  = 2
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [gcc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gcc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            req_type,
  input  logic [7:0]                      temperature,
  input  logic [6:0]                      humidity,
  input  logic [15:0]                     light_level,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            fan_on,
  output logic                            heater_on,
  output logic                            humidifier_on,
  output logic                            dehumidifier_on,
  output logic                            alarm_on,
  output logic [3:0]                      coil_pattern,
  output logic                            shade_is_open,
  output logic                            shade_busy
);
  import gcc_pkg::*;

  cfg_t    cfg;
  item_t   item_q;
  logic    item_full;
  logic    advance;
  result_t result;
  result_t res_q;

  gcc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  gcc_core #(
    .PWM_PERIOD  (PWM_PERIOD),
    .SHADE_STEPS (SHADE_STEPS),
    .STEP_TICKS  (STEP_TICKS)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (item_q),
    .cfg     (cfg),
    .result  (result)
  );

  // move a transaction into the result register when that slot is free
  assign advance  = item_full && (!out_valid || out_ready);
  assign in_ready = !item_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_full <= 1'b0;
    end else if (in_ready) begin
      item_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_q.req_type    <= req_type;
      item_q.temperature <= temperature;
      item_q.humidity    <= humidity;
      item_q.light_level <= light_level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= result;
    end
  end

  assign fan_on          = res_q.fan_on;
  assign heater_on       = res_q.heater_on;
  assign humidifier_on   = res_q.humidifier_on;
  assign dehumidifier_on = res_q.dehumidifier_on;
  assign alarm_on        = res_q.alarm_on;
  assign coil_pattern    = res_q.coil_pattern;
  assign shade_is_open   = res_q.shade_is_open;
  assign shade_busy      = res_q.shade_busy;

endmodule

### design/gcc_cfg.sv
module gcc_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [gcc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gcc_pkg::CFG_DATA_W-1:0]    cfg_data,
  output gcc_pkg::cfg_t                     cfg
);
  import gcc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hum_low    <= 7'd40;
      cfg.hum_high   <= 7'd60;
      cfg.temp_low   <= 7'd21;
      cfg.temp_high  <= 7'd28;
      cfg.light_low  <= 16'd0;
      cfg.light_high <= 16'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HUM_LOW:    cfg.hum_low    <= cfg_data[6:0];
        CFG_HUM_HIGH:   cfg.hum_high   <= cfg_data[6:0];
        CFG_TEMP_LOW:   cfg.temp_low   <= cfg_data[6:0];
        CFG_TEMP_HIGH:  cfg.temp_high  <= cfg_data[6:0];
        CFG_LIGHT_LOW:  cfg.light_low  <= cfg_data;
        CFG_LIGHT_HIGH: cfg.light_high <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

### design/gcc_core.sv
module gcc_core #(
  parameter int PWM_PERIOD  = 3000,
  parameter int SHADE_STEPS = 2150,
  parameter int STEP_TICKS  = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            advance,
  input  gcc_pkg::item_t  item,
  input  gcc_pkg::cfg_t   cfg,
  output gcc_pkg::result_t result
);
  import gcc_pkg::*;

  localparam logic [CNT_W:0]   PERIOD_W   = (CNT_W+1)'(PWM_PERIOD);
  localparam logic [CNT_W-1:0] HALF_CMP   = CNT_W'(PWM_PERIOD / 2);
  localparam logic [CNT_W-1:0] FULL_CMP   = CNT_W'(PWM_PERIOD);
  localparam logic [CNT_W-1:0] STEPS_W    = CNT_W'(SHADE_STEPS);
  localparam logic [1:0]       STEP_TICKS_W = 2'(STEP_TICKS);

  logic [CNT_W-1:0] pwm_counter, pwm_counter_next;
  logic [1:0]       fan_duty, fan_duty_next;
  logic             heater_flag, heater_flag_next;
  logic             humidifier_flag, humidifier_flag_next;
  logic             dehumidifier_flag, dehumidifier_flag_next;
  logic             alarm_flag, alarm_flag_next;
  logic             shade_open_flag, shade_open_flag_next;
  logic             move_active, move_active_next;
  logic             move_direction, move_direction_next;
  logic [CNT_W-1:0] move_step_count, move_step_count_next;
  logic             tick_divider, tick_divider_next;
  logic [3:0]       coil_register, coil_register_next;

  logic [CNT_W:0]   pwm_inc;
  logic [CNT_W-1:0] step_inc;
  logic [8:0]       fan_limit;
  logic             t_high, t_low, h_high, h_low, l_high, l_low;
  logic [CNT_W-1:0] fan_cmp;

  always_comb begin
    pwm_counter_next       = pwm_counter;
    fan_duty_next          = fan_duty;
    heater_flag_next       = heater_flag;
    humidifier_flag_next   = humidifier_flag;
    dehumidifier_flag_next = dehumidifier_flag;
    alarm_flag_next        = alarm_flag;
    shade_open_flag_next   = shade_open_flag;
    move_active_next       = move_active;
    move_direction_next    = move_direction;
    move_step_count_next   = move_step_count;
    tick_divider_next      = tick_divider;
    coil_register_next     = coil_register;

    pwm_inc   = {1'b0, pwm_counter} + (CNT_W+1)'(1);
    step_inc  = move_step_count + CNT_W'(1);
    fan_limit = {3'b000, cfg.temp_high[6:1]} + {2'b00, cfg.temp_high};
    t_high    = item.temperature >= {1'b0, cfg.temp_high};
    t_low     = item.temperature < {1'b0, cfg.temp_low};
    h_high    = item.humidity >= cfg.hum_high;
    h_low     = item.humidity < cfg.hum_low;
    l_high    = item.light_level >= cfg.light_high;
    l_low     = item.light_level < cfg.light_low;

    if (item.req_type == REQ_TICK) begin
      pwm_counter_next = (pwm_inc >= PERIOD_W) ? '0 : pwm_inc[CNT_W-1:0];
      if (move_active) begin
        if ({1'b0, tick_divider} + 2'd1 >= STEP_TICKS_W) begin
          tick_divider_next = 1'b0;
          if (step_inc >= STEPS_W) begin
            // last pattern stays on the coils
            move_active_next     = 1'b0;
            move_step_count_next = '0;
            shade_open_flag_next = (move_direction == DIR_OPEN);
          end else begin
            move_step_count_next = step_inc;
            coil_register_next   = coil_seq(move_direction, step_inc[1:0]);
          end
        end else begin
          tick_divider_next = 1'b1;
        end
      end
    end else begin
      if (t_high) begin
        fan_duty_next = ({1'b0, item.temperature} < fan_limit) ? DUTY_HALF : DUTY_FULL;
      end else begin
        fan_duty_next = DUTY_OFF;
      end
      heater_flag_next = t_low;

      if (h_high || h_low) begin
        if (h_high) dehumidifier_flag_next = 1'b1;
        if (h_low)  humidifier_flag_next   = 1'b1;
      end else begin
        humidifier_flag_next   = 1'b0;
        dehumidifier_flag_next = 1'b0;
      end

      if (l_high || l_low) begin
        if (!move_active) begin
          if (l_low && !shade_open_flag) begin
            move_active_next     = 1'b1;
            move_direction_next  = DIR_OPEN;
            move_step_count_next = '0;
            tick_divider_next    = 1'b0;
            coil_register_next   = coil_seq(DIR_OPEN, 2'd0);
          end else if (l_high && shade_open_flag) begin
            move_active_next     = 1'b1;
            move_direction_next  = DIR_CLOSE;
            move_step_count_next = '0;
            tick_divider_next    = 1'b0;
            coil_register_next   = coil_seq(DIR_CLOSE, 2'd0);
          end
        end
      end else if (!move_active) begin
        coil_register_next = 4'b0000;
      end

      alarm_flag_next = t_high || t_low || h_high || h_low || l_high || l_low;
    end
  end

  always_comb begin
    case (fan_duty_next)
      DUTY_HALF: fan_cmp = HALF_CMP;
      DUTY_FULL: fan_cmp = FULL_CMP;
      default:   fan_cmp = '0;
    endcase
    result.fan_on          = pwm_counter_next < fan_cmp;
    result.heater_on       = heater_flag_next;
    result.humidifier_on   = humidifier_flag_next;
    result.dehumidifier_on = dehumidifier_flag_next;
    result.alarm_on        = alarm_flag_next;
    result.coil_pattern    = coil_register_next;
    result.shade_is_open   = shade_open_flag_next;
    result.shade_busy      = move_active_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_counter       <= '0;
      fan_duty          <= DUTY_OFF;
      heater_flag       <= 1'b0;
      humidifier_flag   <= 1'b0;
      dehumidifier_flag <= 1'b0;
      alarm_flag        <= 1'b0;
      shade_open_flag   <= 1'b0;
      move_active       <= 1'b0;
      move_direction    <= DIR_OPEN;
      move_step_count   <= '0;
      tick_divider      <= 1'b0;
      coil_register     <= 4'b0000;
    end else if (advance) begin
      pwm_counter       <= pwm_counter_next;
      fan_duty          <= fan_duty_next;
      heater_flag       <= heater_flag_next;
      humidifier_flag   <= humidifier_flag_next;
      dehumidifier_flag <= dehumidifier_flag_next;
      alarm_flag        <= alarm_flag_next;
      shade_open_flag   <= shade_open_flag_next;
      move_active       <= move_active_next;
      move_direction    <= move_direction_next;
      move_step_count   <= move_step_count_next;
      tick_divider      <= tick_divider_next;
      coil_register     <= coil_register_next;
    end
  end

endmodule

### tb/sv/climate_checker.sv
`timescale 1ns / 1ps

module climate_checker #(
  parameter int PWM_PERIOD  = 3000,
  parameter int SHADE_STEPS = 2150,
  parameter int STEP_TICKS  = 2
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [gcc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gcc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic                            req_type,
  input  logic [7:0]                      temperature,
  input  logic [6:0]                      humidity,
  input  logic [15:0]                     light_level,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic                            fan_on,
  input  logic                            heater_on,
  input  logic                            humidifier_on,
  input  logic                            dehumidifier_on,
  input  logic                            alarm_on,
  input  logic [3:0]                      coil_pattern,
  input  logic                            shade_is_open,
  input  logic                            shade_busy,
  output int                              mismatches,
  output int                              outstanding
);
  import gcc_pkg::*;

  typedef struct packed {
    logic [11:0] pwm;
    logic [1:0]  duty;
    logic        heater;
    logic        humidify;
    logic        dehumidify;
    logic        alarm;
    logic        shade_open;
    logic        moving;
    logic        dir;
    logic [11:0] steps;
    logic        half_step;
    logic [3:0]  coil;
  } climate_t;

  cfg_t     limits;
  climate_t plant;
  result_t  due_states[$];

  // Closing walks the coils upward; opening walks the same ring mirrored.
  function automatic logic [3:0] coil_phase(input logic dir, input logic [1:0] idx);
    logic [3:0] p;
    case (idx)
      2'd0: p = 4'b0001;
      2'd1: p = 4'b0010;
      2'd2: p = 4'b0100;
      default: p = 4'b1000;
    endcase
    if (dir == DIR_OPEN) p = {p[0], p[1], p[2], p[3]};
    return p;
  endfunction

  function automatic void start_shade(input logic dir);
    plant.moving    = 1'b1;
    plant.dir       = dir;
    plant.steps     = '0;
    plant.half_step = 1'b0;
    plant.coil      = coil_phase(dir, 2'd0);
  endfunction

  function automatic result_t step_climate(input item_t it);
    int t, h, l, th, nxt, duty_cmp;
    logic t_bad, h_bad, l_bad;
    result_t r;
    t  = it.temperature;
    h  = it.humidity;
    l  = it.light_level;
    th = limits.temp_high;
    if (it.req_type == REQ_TICK) begin
      nxt = plant.pwm + 1;
      plant.pwm = (nxt >= PWM_PERIOD) ? 12'd0 : nxt[11:0];
      if (plant.moving) begin
        if (plant.half_step + 1 >= STEP_TICKS) begin
          plant.half_step = 1'b0;
          plant.steps = plant.steps + 12'd1;
          if (plant.steps >= SHADE_STEPS) begin
            // move done: keep the last pattern on the coils
            plant.moving = 1'b0;
            plant.steps = '0;
            plant.shade_open = (plant.dir == DIR_OPEN);
          end else begin
            plant.coil = coil_phase(plant.dir, plant.steps[1:0]);
          end
        end else begin
          plant.half_step = 1'b1;
        end
      end
    end else begin
      t_bad = (t >= th) || (t < limits.temp_low);
      h_bad = (h >= limits.hum_high) || (h < limits.hum_low);
      l_bad = (l >= limits.light_high) || (l < limits.light_low);
      if (t >= th) plant.duty = (t < th / 2 + th) ? DUTY_HALF : DUTY_FULL;
      else plant.duty = DUTY_OFF;
      plant.heater = (t < limits.temp_low);
      if (h_bad) begin
        if (h >= limits.hum_high) plant.dehumidify = 1'b1;
        if (h < limits.hum_low) plant.humidify = 1'b1;
      end else begin
        plant.humidify = 1'b0;
        plant.dehumidify = 1'b0;
      end
      if (l_bad) begin
        if (!plant.moving) begin
          if (l < limits.light_low && !plant.shade_open) start_shade(DIR_OPEN);
          else if (l >= limits.light_high && plant.shade_open) start_shade(DIR_CLOSE);
        end
      end else if (!plant.moving) begin
        plant.coil = '0;
      end
      plant.alarm = t_bad || h_bad || l_bad;
    end
    case (plant.duty)
      DUTY_OFF:  duty_cmp = 0;
      DUTY_HALF: duty_cmp = PWM_PERIOD / 2;
      default:   duty_cmp = PWM_PERIOD;
    endcase
    r.fan_on          = (plant.pwm < duty_cmp);
    r.heater_on       = plant.heater;
    r.humidifier_on   = plant.humidify;
    r.dehumidifier_on = plant.dehumidify;
    r.alarm_on        = plant.alarm;
    r.coil_pattern    = plant.coil;
    r.shade_is_open   = plant.shade_open;
    r.shade_busy      = plant.moving;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [3:0] want, input logic [3:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  initial mismatches = 0;

  always @(posedge clk) begin : watch_channels
    result_t want, got;
    if (rst) begin
      limits = '{hum_low: 7'd40, hum_high: 7'd60, temp_low: 7'd21, temp_high: 7'd28,
                 light_low: 16'd0, light_high: 16'd0};
      plant = '0;
      due_states.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_HUM_LOW:    limits.hum_low    = cfg_data[6:0];
          CFG_HUM_HIGH:   limits.hum_high   = cfg_data[6:0];
          CFG_TEMP_LOW:   limits.temp_low   = cfg_data[6:0];
          CFG_TEMP_HIGH:  limits.temp_high  = cfg_data[6:0];
          CFG_LIGHT_LOW:  limits.light_low  = cfg_data;
          CFG_LIGHT_HIGH: limits.light_high = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        got = {fan_on, heater_on, humidifier_on, dehumidifier_on, alarm_on,
               coil_pattern, shade_is_open, shade_busy};
        if (due_states.size() == 0) begin
          $error("result transaction with no expectation pending: %h", got);
          mismatches++;
        end else begin
          want = due_states.pop_front();
          check_field("fan_on", want.fan_on, got.fan_on);
          check_field("heater_on", want.heater_on, got.heater_on);
          check_field("humidifier_on", want.humidifier_on, got.humidifier_on);
          check_field("dehumidifier_on", want.dehumidifier_on, got.dehumidifier_on);
          check_field("alarm_on", want.alarm_on, got.alarm_on);
          check_field("coil_pattern", want.coil_pattern, got.coil_pattern);
          check_field("shade_is_open", want.shade_is_open, got.shade_is_open);
          check_field("shade_busy", want.shade_busy, got.shade_busy);
        end
      end
      if (in_valid && in_ready)
        due_states.push_back(step_climate({req_type, temperature, humidity, light_level}));
    end
    outstanding <= due_states.size();
  end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import gcc_pkg::*;

  localparam int PWM_PERIOD  = 3000;
  localparam int SHADE_STEPS = 2150;
  localparam int STEP_TICKS  = 2;
  localparam int LIMIT       = 3_000_000;
  localparam int SHADE_RUN   = 4600;

  // indexes past the register list; writes there are ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  logic                  clk, rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid, in_ready;
  logic                  req_type;
  logic [7:0]            temperature;
  logic [6:0]            humidity;
  logic [15:0]           light_level;
  logic                  out_valid, out_ready;
  logic                  fan_on, heater_on, humidifier_on, dehumidifier_on, alarm_on;
  logic [3:0]            coil_pattern;
  logic                  shade_is_open, shade_busy;

  int   mismatches, outstanding, cycle_count, delivered;
  logic calm, held;
  cfg_t aim;

  greenhouse_climate_controller_unit #(
    .PWM_PERIOD(PWM_PERIOD), .SHADE_STEPS(SHADE_STEPS), .STEP_TICKS(STEP_TICKS)
  ) uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .req_type(req_type),
    .temperature(temperature), .humidity(humidity), .light_level(light_level),
    .out_valid(out_valid), .out_ready(out_ready), .fan_on(fan_on), .heater_on(heater_on),
    .humidifier_on(humidifier_on), .dehumidifier_on(dehumidifier_on),
    .alarm_on(alarm_on), .coil_pattern(coil_pattern), .shade_is_open(shade_is_open),
    .shade_busy(shade_busy)
  );

  climate_checker #(
    .PWM_PERIOD(PWM_PERIOD), .SHADE_STEPS(SHADE_STEPS), .STEP_TICKS(STEP_TICKS)
  ) watch (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .req_type(req_type),
    .temperature(temperature), .humidity(humidity), .light_level(light_level),
    .out_valid(out_valid), .out_ready(out_ready), .fan_on(fan_on), .heater_on(heater_on),
    .humidifier_on(humidifier_on), .dehumidifier_on(dehumidifier_on),
    .alarm_on(alarm_on), .coil_pattern(coil_pattern), .shade_is_open(shade_is_open),
    .shade_busy(shade_busy), .mismatches(mismatches), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) delivered <= 0;
    else if (out_valid && out_ready) delivered <= delivered + 1;
  end

  // Receiver: random stalls, plus one long hold-off to back the block up.
  initial begin : receiver
    out_ready <= 1'b0;
    held = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held && delivered >= 400) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (120) @(posedge clk);
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  function automatic int near(input int base, input int spread, input int maxv);
    int v;
    v = base - spread + int'($urandom_range(0, 2 * spread));
    if (v < 0) v = 0;
    if (v > maxv) v = maxv;
    return v;
  endfunction

  function automatic item_t measure(input int t, input int h, input int l);
    item_t it;
    it.req_type    = REQ_MEASURE;
    it.temperature = t[7:0];
    it.humidity    = h[6:0];
    it.light_level = l[15:0];
    return it;
  endfunction

  function automatic item_t tick_item();
    item_t it;
    it = $urandom;
    it.req_type = REQ_TICK;
    return it;
  endfunction

  // Aim half or more of the readings at limits so comparisons flip both ways.
  function automatic item_t rand_measure();
    int t, h, l, th;
    th = aim.temp_high;
    case ($urandom_range(0, 2))
      0: t = $urandom_range(0, 255);
      1: t = near(aim.temp_low, 3, 255);
      default: t = near($urandom_range(0, 1) ? th : th / 2 + th, 3, 255);
    endcase
    case ($urandom_range(0, 3))
      0: h = $urandom_range(0, 127);
      1: h = near(aim.hum_low, 3, 127);
      2: h = near(aim.hum_high, 3, 127);
      default: h = $urandom_range(0, 100);
    endcase
    case ($urandom_range(0, 3))
      0: l = $urandom_range(0, 65535);
      1: l = near(aim.light_low, 3, 65535);
      2: l = near(aim.light_high, 3, 65535);
      default: l = $urandom_range(0, 1) ? 65535 : 0;
    endcase
    return measure(t, h, l);
  endfunction

  function automatic item_t rand_item(input int tick_pct);
    if ($urandom_range(1, 100) <= tick_pct) return tick_item();
    return rand_measure();
  endfunction

  task automatic send(input item_t it);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    {req_type, temperature, humidity, light_level} <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      CFG_HUM_LOW:    aim.hum_low    = data[6:0];
      CFG_HUM_HIGH:   aim.hum_high   = data[6:0];
      CFG_TEMP_LOW:   aim.temp_low   = data[6:0];
      CFG_TEMP_HIGH:  aim.temp_high  = data[6:0];
      CFG_LIGHT_LOW:  aim.light_low  = data;
      CFG_LIGHT_HIGH: aim.light_high = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic configure(input int hl, input int hh, input int tl, input int th,
                           input int ll, input int lh);
    drain();
    repeat (3) @(posedge clk);
    write_reg(CFG_HUM_LOW, hl[15:0]);
    write_reg(CFG_HUM_HIGH, hh[15:0]);
    write_reg(CFG_TEMP_LOW, tl[15:0]);
    write_reg(CFG_TEMP_HIGH, th[15:0]);
    write_reg(CFG_LIGHT_LOW, ll[15:0]);
    write_reg(CFG_LIGHT_HIGH, lh[15:0]);
    write_reg($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO, CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  // Kick a shade move, then mostly tick so the whole move runs out.
  task automatic shade_run(input int l);
    send(measure($urandom_range(0, 255), $urandom_range(0, 127), l));
    repeat (SHADE_RUN) send(rand_item(97));
  endtask

  initial begin : stimulus
    in_valid    <= 1'b0;
    req_type    <= REQ_MEASURE;
    temperature <= '0;
    humidity    <= '0;
    light_level <= '0;
    cfg_we      <= 1'b0;
    cfg_index   <= '0;
    cfg_data    <= '0;
    calm        <= 1'b0;
    rst         <= 1'b1;
    aim = '{hum_low: 7'd40, hum_high: 7'd60, temp_low: 7'd21, temp_high: 7'd28,
            light_low: 16'd0, light_high: 16'd0};
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset limits: fan thresholds, heater edge, latched humidity flags
    send(tick_item());
    send(measure(0, 0, 0));
    send(measure(255, 100, 65535));
    send(measure(28, 40, 0));
    send(measure(41, 59, 0));
    send(measure(42, 60, 0));
    send(measure(27, 127, 0));
    send(measure(20, 39, 0));
    send(measure(21, 50, 0));
    send(tick_item());

    // light window: clear coils, start an opening move, measure during it
    configure(30, 70, 10, 40, 1000, 2000);
    send(measure(25, 50, 1500));
    send(measure(25, 50, 999));
    send(measure(25, 50, 0));
    send(measure(25, 50, 1500));
    repeat (4) send(tick_item());
    send(measure(25, 50, 2000));
    send(measure(60, 50, 1500));
    send(measure(59, 50, 1500));

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: configure(40, 60, 21, 28, 1000, 30000);
        1: configure(0, 16'hFFFF, 0, 0, 0, 16'hFFFF);
        2: configure(99, 0, 99, 5, 16'hFFFF, 0);
        default: configure($urandom_range(0, 65535), $urandom_range(0, 65535),
                           $urandom_range(0, 65535), $urandom_range(0, 65535),
                           $urandom_range(0, 65535), $urandom_range(0, 65535));
      endcase
      if (ph == 5) calm <= 1'b1;
      repeat (200) send(rand_item(50));
      if (ph == 0) begin
        shade_run(0);
        shade_run(65535);
      end
      if (ph == 3) shade_run($urandom_range(0, 65535));
    end

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

### filelist.f
design/gcc_pkg.sv
design/gcc_cfg.sv
design/gcc_core.sv
design/greenhouse_climate_controller_unit.sv
tb/sv/climate_checker.sv
tb/sv/tb.sv
